>>> hdl/engine_rpm_period_meter_defines.svh
// Assertion macros used by the period meter top level.
`ifndef ENGINE_RPM_PERIOD_METER_DEFINES_SVH
`define ENGINE_RPM_PERIOD_METER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ERPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ERPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/erpm_pkg.sv
// Types, constants and codes of the engine rpm period meter.
`default_nettype none

package erpm_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int TS_W       = 32;
    localparam int OP_W       = 2;
    localparam int RPM_W      = 16;
    localparam int PERIOD_W   = 31;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_W      = 26;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int SUM_W      = RPM_W + 3;
    localparam int OUT_DATA_W = ((2 * RPM_W + PERIOD_W + 7) / 8) * 8;

    localparam logic [TS_W-1:0] TIME_MASK = TS_W'((64'd1 << TIME_WIDTH) - 64'd1);

    localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(60000000);
    localparam logic [RPM_W-1:0] RPM_SATURATE  = {RPM_W{1'b1}};

    localparam logic [PERIOD_W-1:0]   MIN_PERIOD_RESET = PERIOD_W'(3000);
    localparam logic [PERIOD_W-1:0]   MAX_PERIOD_RESET = PERIOD_W'(2000000);
    localparam logic [CFG_DATA_W-1:0] STALE_RESET      = CFG_DATA_W'(500000);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STALE      = CFG_IDX_W'(2);

    localparam logic [OP_W-1:0] OP_EDGE      = OP_W'(0);
    localparam int              OP_CLEAR_BIT = 1;

    typedef enum logic [STATUS_W-1:0] {
        STS_ACCEPTED   = 3'd0,
        STS_FIRST      = 3'd1,
        STS_GLITCH     = 3'd2,
        STS_STALL      = 3'd3,
        STS_TICK       = 3'd4,
        STS_TICK_UNANC = 3'd5,
        STS_CLEARED    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV,
        ST_FILT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/erpm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module erpm_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [erpm_pkg::NUM_W-1:0]         dividend,
    input  wire logic [erpm_pkg::PERIOD_W-1:0]      divisor,
    output erpm_pkg::div_stat_t                     stat,
    output logic      [erpm_pkg::NUM_W-1:0]         quotient
);

    logic [erpm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [erpm_pkg::NUM_W-1:0]     quot_reg, quot_next;
    logic [erpm_pkg::PERIOD_W-1:0]  rem_reg, rem_next;
    logic [erpm_pkg::PERIOD_W-1:0]  dvs_reg, dvs_next;
    logic [erpm_pkg::PERIOD_W:0]    shifted;
    logic [erpm_pkg::PERIOD_W:0]    trial;
    logic                           fits;

    // The partial remainder stays below the divisor, so one shift plus the
    // next dividend bit fits in one more bit than the divisor.
    assign shifted = {rem_reg, quot_reg[erpm_pkg::NUM_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = erpm_pkg::DIV_CNT_W'(erpm_pkg::NUM_W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - erpm_pkg::DIV_CNT_W'(1);
            quot_next = {quot_reg[erpm_pkg::NUM_W-2:0], fits};
            rem_next  = fits ? trial[erpm_pkg::PERIOD_W-1:0]
                             : shifted[erpm_pkg::PERIOD_W-1:0];
            done_next = (cnt_reg == erpm_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

`default_nettype wire

>>> hdl/engine_rpm_period_meter.sv
// Top level of the engine rpm period meter: sequencer, state and handshakes.
//
//  Channel   Direction  Signals                                   Payload
//  s_*       in         s_tvalid s_tready s_tdata s_tuser          timestamp_us / operation
//  m_*       out        m_tvalid m_tready m_tdata m_tuser          rpm, period / status
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data     register write
//
// A valid pulse edge raises m_tvalid once it is classified, run through the bit-serial
// 60000000 / period (26 quotient bits, then a done strobe), filtered and loaded into the
// output register. A zero-period edge skips the divider; other requests skip it and the
// filter. s_tready returns in the cycle after the load, so a request is taken only once
// the last is through. Reset clears the state and loads the default registers. A waiting
// result does not block the next request, which then holds until the output register frees.
`default_nettype none
`include "engine_rpm_period_meter_defines.svh"

module engine_rpm_period_meter (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Requests. s_tdata: timestamp_us[31:0]. s_tuser: operation[1:0].
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [erpm_pkg::TS_W-1:0]             s_tdata,
    input  wire logic [erpm_pkg::OP_W-1:0]             s_tuser,
    // Results. m_tdata: smooth_rpm[15:0], instant_rpm[31:16],
    // period_us[62:32], zero pad[63]. m_tuser: status[2:0].
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [erpm_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic      [erpm_pkg::STATUS_W-1:0]         m_tuser,
    // Register writes.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [erpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [erpm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    erpm_pkg::state_t                     state_reg, state_next;
    erpm_pkg::status_t                    status_reg;
    logic [erpm_pkg::OP_W-1:0]            op_reg;
    logic [erpm_pkg::TS_W-1:0]            ts_reg;
    logic                                 anchored_reg;
    logic [erpm_pkg::TS_W-1:0]            last_edge_reg;
    logic [erpm_pkg::PERIOD_W-1:0]        last_period_reg;
    logic [erpm_pkg::RPM_W-1:0]           raw_rpm_reg;
    logic [erpm_pkg::RPM_W-1:0]           filt_rpm_reg;
    logic [erpm_pkg::RPM_W-1:0]           inst_reg;
    logic [erpm_pkg::PERIOD_W-1:0]        min_reg;
    logic [erpm_pkg::PERIOD_W-1:0]        max_reg;
    logic [erpm_pkg::CFG_DATA_W-1:0]      stale_reg;
    logic                                 m_tvalid_reg;
    logic [erpm_pkg::RPM_W-1:0]           out_smooth_reg;
    logic [erpm_pkg::RPM_W-1:0]           out_inst_reg;
    logic [erpm_pkg::PERIOD_W-1:0]        out_period_reg;
    logic [erpm_pkg::STATUS_W-1:0]        out_status_reg;

    logic                                 in_accept;
    logic                                 out_load;
    logic [erpm_pkg::TS_W-1:0]            gap;
    logic                                 is_clear;
    logic                                 is_edge;
    logic                                 short_gap;
    logic                                 long_gap;
    logic                                 zero_gap;
    logic                                 stale_gap;
    logic                                 dead_gap;
    logic                                 div_start;
    erpm_pkg::div_stat_t                  div_stat;
    logic [erpm_pkg::NUM_W-1:0]           div_quot;
    logic [erpm_pkg::RPM_W-1:0]           quot_sat;
    logic [erpm_pkg::SUM_W-1:0]           filt_sum;

    // Elapsed time since the anchor edge, modulo the timestamp range.
    assign gap       = (ts_reg - last_edge_reg) & erpm_pkg::TIME_MASK;
    assign is_clear  = op_reg[erpm_pkg::OP_CLEAR_BIT];
    assign is_edge   = (op_reg == erpm_pkg::OP_EDGE);
    assign short_gap = (gap < {1'b0, min_reg});
    assign long_gap  = (gap > {1'b0, max_reg});
    assign zero_gap  = (gap == '0);
    assign stale_gap = (gap > stale_reg);
    // Twice the maximum period is exactly one left shift, no overflow.
    assign dead_gap  = (gap > {max_reg, 1'b0});

    assign quot_sat = (div_quot[erpm_pkg::NUM_W-1:erpm_pkg::RPM_W] != '0)
                    ? erpm_pkg::RPM_SATURATE : div_quot[erpm_pkg::RPM_W-1:0];

    // Seven eighths of the old value plus one eighth of the new one.
    assign filt_sum = {filt_rpm_reg, 3'b000} - {3'b000, filt_rpm_reg}
                    + {3'b000, inst_reg};

    erpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (erpm_pkg::RPM_NUMERATOR),
        .divisor  (gap[erpm_pkg::PERIOD_W-1:0]),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            erpm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = erpm_pkg::ST_CLASS;
                end
            end
            erpm_pkg::ST_CLASS:
            begin
                if (!is_clear && is_edge && anchored_reg && !short_gap && !long_gap)
                begin
                    state_next = zero_gap ? erpm_pkg::ST_FILT : erpm_pkg::ST_DIV;
                end
                else
                begin
                    state_next = erpm_pkg::ST_DONE;
                end
            end
            erpm_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = erpm_pkg::ST_FILT;
                end
            end
            erpm_pkg::ST_FILT:
            begin
                state_next = erpm_pkg::ST_DONE;
            end
            erpm_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = erpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = erpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            erpm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            erpm_pkg::ST_CLASS:
            begin
                div_start = !is_clear && is_edge && anchored_reg
                          && !short_gap && !long_gap && !zero_gap;
            end
            erpm_pkg::ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= erpm_pkg::ST_IDLE;
            status_reg      <= erpm_pkg::STS_ACCEPTED;
            anchored_reg    <= 1'b0;
            last_edge_reg   <= '0;
            last_period_reg <= '0;
            raw_rpm_reg     <= '0;
            filt_rpm_reg    <= '0;
            min_reg         <= erpm_pkg::MIN_PERIOD_RESET;
            max_reg         <= erpm_pkg::MAX_PERIOD_RESET;
            stale_reg       <= erpm_pkg::STALE_RESET;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    erpm_pkg::CFG_MIN_PERIOD: min_reg   <= cfg_data[erpm_pkg::PERIOD_W-1:0];
                    erpm_pkg::CFG_MAX_PERIOD: max_reg   <= cfg_data[erpm_pkg::PERIOD_W-1:0];
                    erpm_pkg::CFG_STALE:      stale_reg <= cfg_data;
                    default:                  ;
                endcase
            end

            unique case (state_reg)
                erpm_pkg::ST_CLASS:
                begin
                    priority if (is_clear)
                    begin
                        anchored_reg    <= 1'b0;
                        last_edge_reg   <= '0;
                        last_period_reg <= '0;
                        raw_rpm_reg     <= '0;
                        filt_rpm_reg    <= '0;
                        status_reg      <= erpm_pkg::STS_CLEARED;
                    end
                    else if (is_edge)
                    begin
                        priority if (!anchored_reg)
                        begin
                            anchored_reg  <= 1'b1;
                            last_edge_reg <= ts_reg;
                            status_reg    <= erpm_pkg::STS_FIRST;
                        end
                        else if (short_gap)
                        begin
                            status_reg <= erpm_pkg::STS_GLITCH;
                        end
                        else if (long_gap)
                        begin
                            last_edge_reg   <= ts_reg;
                            last_period_reg <= '0;
                            raw_rpm_reg     <= '0;
                            filt_rpm_reg    <= '0;
                            status_reg      <= erpm_pkg::STS_STALL;
                        end
                        else
                        begin
                            last_edge_reg   <= ts_reg;
                            last_period_reg <= gap[erpm_pkg::PERIOD_W-1:0];
                            status_reg      <= erpm_pkg::STS_ACCEPTED;
                        end
                    end
                    else
                    begin
                        if (!anchored_reg)
                        begin
                            status_reg <= erpm_pkg::STS_TICK_UNANC;
                        end
                        else
                        begin
                            if (stale_gap)
                            begin
                                raw_rpm_reg  <= '0;
                                filt_rpm_reg <= '0;
                            end
                            if (dead_gap)
                            begin
                                last_period_reg <= '0;
                            end
                            status_reg <= erpm_pkg::STS_TICK;
                        end
                    end
                end
                erpm_pkg::ST_FILT:
                begin
                    raw_rpm_reg  <= inst_reg;
                    filt_rpm_reg <= filt_sum[erpm_pkg::SUM_W-1:3];
                end
                default:
                begin
                    status_reg <= status_reg;
                end
            endcase

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= s_tuser;
            ts_reg <= s_tdata & erpm_pkg::TIME_MASK;
        end
        // A zero period saturates without running the divider.
        if (state_reg == erpm_pkg::ST_CLASS)
        begin
            inst_reg <= erpm_pkg::RPM_SATURATE;
        end
        else if (state_reg == erpm_pkg::ST_DIV && div_stat.done)
        begin
            inst_reg <= quot_sat;
        end
        if (out_load)
        begin
            out_smooth_reg <= filt_rpm_reg;
            out_inst_reg   <= raw_rpm_reg;
            out_period_reg <= last_period_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_period_reg, out_inst_reg, out_smooth_reg};
    assign m_tuser  = out_status_reg;

    // The divider only runs while the sequencer waits on it.
    `ERPM_ASSERT_NOW(a_div_owned, clk, rst_n, div_stat.busy, state_reg == erpm_pkg::ST_DIV,
        "divider busy outside the divide state")
    // A stall result always reports zeroed readings.
    `ERPM_ASSERT_NOW(a_stall_zero, clk, rst_n,
        m_tvalid && (m_tuser == erpm_pkg::STS_STALL),
        (m_tdata[erpm_pkg::OUT_DATA_W-2:0] == '0), "stall result with nonzero readings")
    // An accepted request moves straight into classification.
    `ERPM_ASSERT_NEXT(a_accept_class, clk, rst_n, in_accept,
        state_reg == erpm_pkg::ST_CLASS, "accepted request not classified")
    // An edge always leaves the meter anchored, whether or not it was anchored before.
    `ERPM_ASSERT_NEXT(a_anchor_set, clk, rst_n,
        (state_reg == erpm_pkg::ST_CLASS) && !is_clear && is_edge, anchored_reg,
        "edge did not leave the meter anchored")

endmodule

`default_nettype wire

>>> tb/erpm_checker.sv
// Scoreboard for the engine rpm period meter: predicts each reading and compares it.
`timescale 1ns / 1ps

module erpm_checker
    import erpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [TS_W-1:0]       s_tdata,
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [STATUS_W-1:0]   m_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);

    localparam logic [TS_W-1:0]  RPM_PER_HZ_US = 32'd60_000_000;
    localparam logic [SUM_W-1:0] FILTER_KEEP   = SUM_W'(7);
    localparam int               FILTER_SHIFT  = 3;
    localparam int               PAD_LSB       = 2 * RPM_W + PERIOD_W;

    typedef struct packed {
        logic [RPM_W-1:0]    smooth;
        logic [RPM_W-1:0]    instant;
        logic [PERIOD_W-1:0] period;
        status_t             status;
    } reading_t;

    logic [PERIOD_W-1:0]   min_period;
    logic [PERIOD_W-1:0]   max_period;
    logic [CFG_DATA_W-1:0] stale_gap;

    logic                  anchored;
    logic [TS_W-1:0]       last_edge_ts;
    logic [PERIOD_W-1:0]   last_period;
    logic [RPM_W-1:0]      raw_rpm;
    logic [RPM_W-1:0]      filtered_rpm;

    reading_t expected_readings[$];

    function automatic void clear_meter();
        anchored     = 1'b0;
        last_edge_ts = '0;
        last_period  = '0;
        raw_rpm      = '0;
        filtered_rpm = '0;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("meter mismatch on %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    // Applies one request to the tracked meter state and returns the reading it yields.
    function automatic reading_t advance_meter(input logic [OP_W-1:0] op,
                                               input logic [TS_W-1:0] ts);
        reading_t        r;
        logic [TS_W-1:0] span;
        logic [TS_W-1:0] rpm_full;
        logic [SUM_W-1:0] sum;
        span = (ts - last_edge_ts) & TIME_MASK;
        if (op[OP_CLEAR_BIT])
        begin
            clear_meter();
            r.status = STS_CLEARED;
        end
        else if (op == OP_EDGE)
        begin
            if (!anchored)
            begin
                anchored     = 1'b1;
                last_edge_ts = ts & TIME_MASK;
                r.status     = STS_FIRST;
            end
            else if (span < {1'b0, min_period})
            begin
                r.status = STS_GLITCH;
            end
            else if (span > {1'b0, max_period})
            begin
                last_edge_ts = ts & TIME_MASK;
                last_period  = '0;
                raw_rpm      = '0;
                filtered_rpm = '0;
                r.status     = STS_STALL;
            end
            else
            begin
                last_edge_ts = ts & TIME_MASK;
                last_period  = span[PERIOD_W-1:0];
                // A zero period is only possible with a zero minimum; it saturates.
                rpm_full = (span == '0) ? TS_W'(RPM_SATURATE) : RPM_PER_HZ_US / span;
                if (rpm_full > TS_W'(RPM_SATURATE))
                    rpm_full = TS_W'(RPM_SATURATE);
                raw_rpm      = rpm_full[RPM_W-1:0];
                sum          = SUM_W'(filtered_rpm) * FILTER_KEEP + SUM_W'(raw_rpm);
                filtered_rpm = sum[FILTER_SHIFT +: RPM_W];
                r.status     = STS_ACCEPTED;
            end
        end
        else if (!anchored)
        begin
            r.status = STS_TICK_UNANC;
        end
        else
        begin
            if (span > stale_gap)
            begin
                raw_rpm      = '0;
                filtered_rpm = '0;
            end
            // Twice the maximum still fits in 32 bits since the register is 31 bits wide.
            if (span > {max_period, 1'b0})
                last_period = '0;
            r.status = STS_TICK;
        end
        r.smooth  = filtered_rpm;
        r.instant = raw_rpm;
        r.period  = last_period;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t got;
        if (!rst_n)
        begin
            min_period = MIN_PERIOD_RESET;
            max_period = MAX_PERIOD_RESET;
            stale_gap  = STALE_RESET;
            clear_meter();
            expected_readings.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_PERIOD: min_period = cfg_data[PERIOD_W-1:0];
                    CFG_MAX_PERIOD: max_period = cfg_data[PERIOD_W-1:0];
                    CFG_STALE:      stale_gap  = cfg_data;
                    default:        ;
                endcase
            end
            // Results leave before new requests are scored, so a stray result is never
            // matched against a request taken on the same edge.
            if (m_tvalid && m_tready)
            begin
                got.smooth  = m_tdata[RPM_W-1:0];
                got.instant = m_tdata[RPM_W +: RPM_W];
                got.period  = m_tdata[2*RPM_W +: PERIOD_W];
                got.status  = status_t'(m_tuser);
                if (expected_readings.size() == 0)
                begin
                    report("result with no request pending", 32'(m_tuser), 32'd0);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.smooth != want.smooth)
                        report("smooth_rpm", 32'(got.smooth), 32'(want.smooth));
                    if (got.instant != want.instant)
                        report("instant_rpm", 32'(got.instant), 32'(want.instant));
                    if (got.period != want.period)
                        report("period_us", 32'(got.period), 32'(want.period));
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (m_tdata[OUT_DATA_W-1:PAD_LSB] != '0)
                        report("tdata padding", 32'(m_tdata[OUT_DATA_W-1:PAD_LSB]), 32'd0);
                end
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(advance_meter(s_tuser, s_tdata));
            pending <= expected_readings.size();
        end
    end

endmodule

>>> tb/tb_engine_rpm_period_meter.sv
// Top of the period meter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_engine_rpm_period_meter;

    import erpm_pkg::*;

    // Operation codes beyond the pulse edge. Code three carries the clear bit as well,
    // so it must behave exactly like a clear.
    localparam logic [OP_W-1:0]      OP_TICK        = OP_W'(1);
    localparam logic [OP_W-1:0]      OP_CLEAR       = OP_W'(2);
    localparam logic [OP_W-1:0]      OP_CLEAR_ALIAS = OP_W'(3);
    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = CFG_IDX_W'(3);

    localparam int MAX_GAP        = 8;
    // The pause before a register write and at the end of the run outlasts the time a valid
    // edge holds the block, leaving a comfortable margin on top of it.
    localparam int SETTLE_CYCLES  = 40;
    // Longest quiet stretch of a correct run: one edge in the divider, a full sender gap,
    // a full receiver stall and a settle pause. The limit is many times that.
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 240;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TS_W-1:0]       s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // While calm is set, neither side idles, giving back-to-back stretches.
    bit calm = 1'b0;

    // A rough view of the meter's anchor, used only to aim timestamps at the
    // interesting period ranges. The checker keeps the exact state.
    logic            anchored_view = 1'b0;
    logic [TS_W-1:0] anchor_view   = '0;
    logic [31:0]     cur_min       = 32'(MIN_PERIOD_RESET);
    logic [31:0]     cur_max       = 32'(MAX_PERIOD_RESET);
    logic [31:0]     cur_stale     = STALE_RESET;

    engine_rpm_period_meter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    erpm_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sends one request after a random gap. The valid line is only lowered when a gap is
    // drawn, so back-to-back requests never see valid dropped and raised in one step.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ts;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        // Follow the anchor the way the meter moves it: glitches leave it alone.
        if (op[OP_CLEAR_BIT])
        begin
            anchored_view = 1'b0;
        end
        else if (op == OP_EDGE)
        begin
            if (!anchored_view || (ts - anchor_view) >= cur_min)
                anchor_view = ts;
            anchored_view = 1'b1;
        end
    endtask

    // Drops valid, waits for every outstanding result, then lets the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write of a batch.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all three registers while the block is idle. The 31-bit registers get their
    // top data bit from the caller, which must be masked off by the block.
    task automatic load_registers(input logic [31:0] min_word, input logic [31:0] max_word,
                                  input logic [31:0] stale_word);
        settle();
        write_register(CFG_SPARE, $urandom);
        write_register(CFG_MIN_PERIOD, min_word);
        write_register(CFG_MAX_PERIOD, max_word);
        write_register(CFG_STALE, stale_word);
        cfg_valid <= 1'b0;
        cur_min   = {1'b0, min_word[30:0]};
        cur_max   = {1'b0, max_word[30:0]};
        cur_stale = stale_word;
    endtask

    // Draws a span between lo and hi, leaning on both ends and on short spans near lo,
    // which is where the high rpm readings and the boundaries live.
    function automatic logic [TS_W-1:0] pick_span(input logic [TS_W-1:0] lo,
                                                  input logic [TS_W-1:0] hi);
        logic [TS_W-1:0] reach;
        reach = (hi - lo > 32'd4000) ? 32'd4000 : hi - lo;
        case ($urandom_range(5, 0))
            0:       return lo;
            1:       return hi;
            2, 3:    return $urandom_range(hi, lo);
            default: return lo + $urandom_range(reach, 0);
        endcase
    endfunction

    // Mostly well-formed edges with valid periods, plus glitches, stalls, ticks aimed at
    // both timeouts and the odd clear.
    task automatic random_request();
        int unsigned     roll;
        logic [TS_W-1:0] span;
        logic [OP_W-1:0] op;
        roll = $urandom_range(99, 0);
        op   = OP_EDGE;
        if (roll < 2)
        begin
            op   = ($urandom_range(1, 0) == 1) ? OP_CLEAR : OP_CLEAR_ALIAS;
            span = $urandom;
        end
        else if (roll < 14)
        begin
            op = OP_TICK;
            case ($urandom_range(3, 0))
                0:       span = cur_stale + $urandom_range(2, 0) - 1;
                1:       span = {cur_max[30:0], 1'b0} + $urandom_range(2, 0) - 1;
                default: span = pick_span('0, '1);
            endcase
        end
        else if (roll < 22 && cur_min != 0)
            span = pick_span('0, cur_min - 1);
        else if (roll < 30)
            span = pick_span(cur_max + 1, '1);
        else if (cur_min <= cur_max)
            span = pick_span(cur_min, cur_max);
        else
            span = pick_span('0, '1);
        send_request(op, anchor_view + span);
    endtask

    // Result side: a fresh stall is drawn for every result.
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(MAX_GAP, 0);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Watchdog: any accepted request, result or register write restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [TS_W-1:0] t;
        logic [31:0]     mn;
        logic [31:0]     mx;
        logic [31:0]     st;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: a tick before any edge, then anchoring across the wrap.
        send_request(OP_TICK, 32'h1234_5678);
        t = 32'hFFFF_F000;
        send_request(OP_EDGE, t);
        send_request(OP_EDGE, t + 1000);
        // The next edge lies past the wrap of the timestamp.
        t = 32'h0000_2000;
        send_request(OP_EDGE, t);
        send_request(OP_EDGE, t + 2999);
        t = t + 3000;
        send_request(OP_EDGE, t);
        t = t + 2_000_000;
        send_request(OP_EDGE, t);
        // Ticks right at and just past the display timeout and twice the maximum period.
        send_request(OP_TICK, t + 500_000);
        send_request(OP_TICK, t + 500_001);
        send_request(OP_TICK, t + 4_000_000);
        send_request(OP_TICK, t + 4_000_001);
        send_request(OP_EDGE, t + 2_000_001);
        send_request(OP_CLEAR_ALIAS, $urandom);
        send_request(OP_TICK, $urandom);
        send_request(OP_CLEAR, $urandom);

        // Zero minimum, largest maximum, zero display timeout. The top data bits of the
        // 31-bit registers are set and must be dropped.
        load_registers(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        t = 32'h4000_0000;
        send_request(OP_EDGE, t);
        send_request(OP_EDGE, t);
        send_request(OP_EDGE, t + 1);
        t = t + 1;
        send_request(OP_EDGE, t + 916);
        t = t + 916;
        send_request(OP_TICK, t);
        send_request(OP_TICK, t + 1);
        send_request(OP_EDGE, t + 32'h7FFF_FFFF);
        t = t + 32'h7FFF_FFFF;
        // A gap of all ones exceeds twice the largest maximum only by one.
        send_request(OP_TICK, t + 32'hFFFF_FFFF);
        send_request(OP_EDGE, t + 32'h8000_0000);

        // Minimum above maximum: the glitch test wins below the minimum, stall above it.
        load_registers(32'd100, 32'd50, 32'hFFFF_FFFF);
        t = anchor_view;
        send_request(OP_EDGE, t + 75);
        send_request(OP_EDGE, t + 200);
        t = t + 200;
        send_request(OP_TICK, t + 32'hFFFF_FFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(3, 0))
                0:
                begin
                    mn = 32'(MIN_PERIOD_RESET);
                    mx = 32'(MAX_PERIOD_RESET);
                    st = STALE_RESET;
                end
                1:
                begin
                    mn = $urandom_range(1000, 0);
                    mx = mn + $urandom_range(60_000, 1);
                    st = $urandom_range(100_000, 0);
                end
                2:
                begin
                    mn = $urandom_range(32'h7FFF_FFFF, 1);
                    mx = $urandom_range(32'h7FFF_FFFF, 1);
                    st = $urandom;
                end
                default:
                begin
                    mn = $urandom_range(5000, 1);
                    mx = $urandom_range(32'h7FFF_FFFF, mn);
                    st = $urandom;
                end
            endcase
            load_registers({1'($urandom_range(1, 0)), mn[30:0]},
                           {1'($urandom_range(1, 0)), mx[30:0]}, st);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (n % 48 == 0)
                    calm = ($urandom_range(3, 0) == 0);
                random_request();
            end
            calm = 1'b0;
        end

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/erpm_pkg.sv
hdl/erpm_div.sv
hdl/engine_rpm_period_meter.sv
tb/erpm_checker.sv
tb/tb_engine_rpm_period_meter.sv
